/* rtl/vpc_pkg.sv */
`default_nettype none

package vpc_pkg;

  // Alphabet: printable codes 32 to 126
  localparam int unsigned FIRST_CODE  = 32;
  localparam int unsigned LAST_CODE   = 126;
  localparam int unsigned ALPHA_SIZE  = LAST_CODE + 1 - FIRST_CODE;

  // Key store
  localparam int unsigned MAX_KEY_LEN = 16;
  localparam int unsigned KEY_POS_W   = $clog2(MAX_KEY_LEN);
  localparam int unsigned KEY_LEN_W   = 5;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned SYM_W       = 7;
  localparam int unsigned SALT_W      = 7;

  // Configuration port
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SALT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT  = 3'd4;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              restart;
  } vpc_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] result_char;
    logic              out_of_range;
  } vpc_out_t;

endpackage

`default_nettype wire

/* rtl/vigenere_printable_cipher_top.sv */
`default_nettype none

// Channel  | Ports                          | Payload
// ---------+--------------------------------+------------------------------
// input    | in_valid, in_stall, in_data    | text_char, restart
// result   | out_valid, out_stall, out_data | result_char, out_of_range
// config   | cfg_we, cfg_index, cfg_wdata   | registers 0..4, 64-bit data
//
// One item per cycle sustained while out_stall lets the result register drain;
// an accepted item goes through the stage 1 register, then the result register.
// Stage 1 picks the key byte and folds key and salt into one shift mod 95;
// stage 2 applies the shift with a single compare-and-subtract.
// Sync active-low reset clears pipeline, key position, registers (key len 1).
// out_stall holds the result register; in_stall rises only when both stages
// are full and the result is stalled.

module vigenere_printable_cipher_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire vpc_pkg::vpc_in_t            in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output vpc_pkg::vpc_out_t                out_data,
  input  wire                              cfg_we,
  input  wire [vpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [vpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam logic [vpc_pkg::CHAR_W-1:0] FIRST_C = vpc_pkg::CHAR_W'(vpc_pkg::FIRST_CODE);
  localparam logic [vpc_pkg::CHAR_W-1:0] LAST_C  = vpc_pkg::CHAR_W'(vpc_pkg::LAST_CODE);
  localparam logic [vpc_pkg::CHAR_W-1:0] ALPHA_C = vpc_pkg::CHAR_W'(vpc_pkg::ALPHA_SIZE);
  localparam logic [vpc_pkg::KEY_LEN_W-1:0] MAX_LEN =
    vpc_pkg::KEY_LEN_W'(vpc_pkg::MAX_KEY_LEN);

  // Configuration registers
  logic [vpc_pkg::CFG_DATA_W-1:0] key_low_r, key_high_r;
  logic [vpc_pkg::KEY_LEN_W-1:0]  key_len_r;
  logic [vpc_pkg::SALT_W-1:0]     salt_r;
  logic                           decrypt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= vpc_pkg::KEY_LEN_W'(1);
      salt_r     <= '0;
      decrypt_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vpc_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        vpc_pkg::CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        vpc_pkg::CFG_KEY_LEN:  key_len_r  <= cfg_wdata[vpc_pkg::KEY_LEN_W-1:0];
        vpc_pkg::CFG_SALT:     salt_r     <= cfg_wdata[vpc_pkg::SALT_W-1:0];
        vpc_pkg::CFG_DECRYPT:  decrypt_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic s1_v_r, out_v_r;
  logic out_free, s1_free, in_acc;

  assign out_free = !out_v_r || !out_stall;
  assign s1_free  = !s1_v_r || out_free;
  assign in_stall = !s1_free;
  assign in_acc   = in_valid && s1_free;

  // Effective key length, clamped to 1..MAX_KEY_LEN
  logic [vpc_pkg::KEY_LEN_W-1:0] eff_len;
  always_comb begin
    priority if (key_len_r == '0)     eff_len = vpc_pkg::KEY_LEN_W'(1);
    else if (key_len_r > MAX_LEN)     eff_len = MAX_LEN;
    else                              eff_len = key_len_r;
  end

  // Key position for this item and the next one
  logic [vpc_pkg::KEY_POS_W-1:0] key_pos_r, key_pos_nxt, pos;
  logic [vpc_pkg::KEY_LEN_W-1:0] pos_ext, next_ext;

  always_comb begin
    pos = in_data.restart ? '0 : key_pos_r;
    if (vpc_pkg::KEY_LEN_W'(pos) >= eff_len) pos = '0;
    pos_ext  = vpc_pkg::KEY_LEN_W'(pos);
    next_ext = pos_ext + vpc_pkg::KEY_LEN_W'(1);
    if (next_ext >= eff_len) next_ext = '0;
    key_pos_nxt = next_ext[vpc_pkg::KEY_POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) key_pos_r <= '0;
    else if (in_acc) key_pos_r <= key_pos_nxt;
  end

  // Key byte at the position, reduced to an alphabet offset 0..94
  logic [2*vpc_pkg::CFG_DATA_W-1:0] key_all;
  logic [vpc_pkg::CHAR_W-1:0]       key_byte, key_off8, salt8, ks8;
  logic [vpc_pkg::SYM_W-1:0]        ks;

  assign key_all  = {key_high_r, key_low_r};
  assign key_byte = key_all[{pos, 3'b000} +: vpc_pkg::CHAR_W];

  always_comb begin
    priority if (key_byte < FIRST_C)
      key_off8 = key_byte + (ALPHA_C - FIRST_C);
    else if (key_byte <= LAST_C)
      key_off8 = key_byte - FIRST_C;
    else if (key_byte <= LAST_C + ALPHA_C)
      key_off8 = key_byte - (FIRST_C + ALPHA_C);
    else
      key_off8 = key_byte - (FIRST_C + ALPHA_C + ALPHA_C);

    salt8 = vpc_pkg::CHAR_W'(salt_r);
    if (salt8 >= ALPHA_C) salt8 = salt8 - ALPHA_C;

    // combined shift mod 95
    ks8 = key_off8 + salt8;
    if (ks8 >= ALPHA_C) ks8 = ks8 - ALPHA_C;
    ks = ks8[vpc_pkg::SYM_W-1:0];
  end

  // Stage 1 register
  logic [vpc_pkg::CHAR_W-1:0] s1_char_r;
  logic                       s1_bad_r;
  logic [vpc_pkg::SYM_W-1:0]  s1_ks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (s1_free) s1_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_data.text_char;
      s1_bad_r  <= (in_data.text_char < FIRST_C) || (in_data.text_char > LAST_C);
      s1_ks_r   <= ks;
    end
  end

  // Stage 2: apply the shift
  logic [vpc_pkg::CHAR_W-1:0] sym8, t8, res_char;

  always_comb begin
    sym8 = s1_char_r - FIRST_C;
    if (decrypt_r) t8 = sym8 + ALPHA_C - vpc_pkg::CHAR_W'(s1_ks_r);
    else           t8 = sym8 + vpc_pkg::CHAR_W'(s1_ks_r);
    if (t8 >= ALPHA_C) t8 = t8 - ALPHA_C;
    res_char = s1_bad_r ? s1_char_r : t8 + FIRST_C;
  end

  // Result register
  vpc_pkg::vpc_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (out_free) out_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_v_r) begin
      out_r.result_char  <= res_char;
      out_r.out_of_range <= s1_bad_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
